// ----- sv/rro_pkg.sv -----
// Package for the RIP-relative offset relocator: transaction types, opcode
// constants and the long-header match function. No dependencies.
package rro_pkg;

  localparam int unsigned QueueDepthDef = 2;

  localparam logic [7:0] RexW      = 8'h48;
  localparam logic [7:0] RexWR     = 8'h4C;
  localparam logic [7:0] OpLea     = 8'h8D;
  localparam logic [7:0] OpMov     = 8'h8B;
  localparam logic [7:0] OpCmp     = 8'h3B;
  localparam logic [7:0] OpGrp5    = 8'hFF;
  localparam logic [7:0] ModrmCall = 8'h15;
  localparam logic [7:0] ModrmJmp  = 8'h25;
  localparam logic [7:0] OpCall    = 8'hE8;
  localparam logic [7:0] OpJmp     = 8'hE9;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } rro_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       was_patched;
    logic       end_of_region;
  } rro_out_t;

  // Window snapshot handed from front to back: cnt is the number of valid bytes.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
  } rro_rec_t;

  function automatic logic long_header(logic [7:0] p, logic [7:0] op, logic [7:0] m);
    logic [7:0] regmask;
    logic       hit;
    regmask = 8'h00;
    hit     = 1'b0;
    if ((m & 8'hC7) == 8'h05) begin
      if (p == RexW && op == OpLea) begin
        regmask = 8'h06;
      end else if (p == RexW && op == OpCmp) begin
        regmask = 8'h0E;
      end else if ((p inside {RexW, RexWR}) && op == OpMov) begin
        regmask = 8'hFF;
      end else if (p == RexWR && op == OpCmp) begin
        regmask = 8'hFF;
      end
      hit = regmask[m[5:3]];
    end
    return hit;
  endfunction

endpackage

// ----- sv/rip_relative_offset_relocator_unit.sv -----
// Top level of the RIP-relative offset relocator: front window, item queue,
// back-end patcher and result queue. Depends on rro_pkg and its submodules.
// Throughput: one byte per cycle while neither queue is full; a region end flushes up to 3 bytes.
// Path: a byte reaches the result ports after the input transaction that completes its
// two-byte lookahead (or ends the region) has gone through the item queue and the back end.
// Reset (async, active low) clears the window, match state, queues and delta.
module rip_relative_offset_relocator_unit import rro_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  rro_in_t     in_i,
  output logic        empty,
  input  logic        pop,
  output rro_out_t    out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic     rec_push, rec_full, rec_pop, rec_empty;
  rro_rec_t rec_in, rec_head;
  logic     out_push, out_full;
  rro_out_t out_data;

  assign cfg_ready_o = 1'b1;

  rro_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_i       (in_i),
    .full_o     (full),
    .rec_push_o (rec_push),
    .rec_o      (rec_in),
    .rec_full_i (rec_full)
  );

  rro_fifo #(.T(rro_rec_t), .Depth(QueueDepth)) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .data_i  (rec_in),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .data_o  (rec_head),
    .empty_o (rec_empty)
  );

  rro_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .rec_i       (rec_head),
    .rec_empty_i (rec_empty),
    .rec_pop_o   (rec_pop),
    .out_push_o  (out_push),
    .out_o       (out_data),
    .out_full_i  (out_full)
  );

  rro_fifo #(.T(rro_out_t), .Depth(QueueDepth)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_data),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_o),
    .empty_o (empty)
  );

`ifndef SYNTH
  a_rec_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push |-> !rec_full) else $error("item queue overflow");

  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> (!out_full && !rec_empty)) else $error("result queue overflow");

  a_eor_retires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push && out_data.end_of_region) |-> rec_pop)
    else $error("end of region without retiring the window transaction");
`endif

endmodule

// ----- sv/rro_fifo.sv -----
// Small register FIFO carrying one transaction type.
// Depends on nothing but its parameters.
module rro_fifo #(
  parameter type         T     = logic,
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  T                mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/rro_front.sv -----
// Front end: two-byte lookahead window; emits a window snapshot for each accepted byte that fills or ends it.
// Depends on rro_pkg.
module rro_front import rro_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  rro_in_t  in_i,
  output logic     full_o,
  output logic     rec_push_o,
  output rro_rec_t rec_o,
  input  logic     rec_full_i
);

  logic [1:0][7:0] win_d, win_q;
  logic [1:0]      cnt_d, cnt_q;
  logic [2:0][7:0] v;
  logic [1:0]      n1;
  logic            accept, hold;

  assign full_o = rec_full_i;
  assign accept = push_i && !rec_full_i;

  always_comb begin
    v        = {8'h00, win_q[1], win_q[0]};
    case (cnt_q)
      2'd0:    v[0] = in_i.code_byte;
      2'd1:    v[1] = in_i.code_byte;
      default: v[2] = in_i.code_byte;
    endcase
    n1         = cnt_q + 2'd1;
    hold       = !in_i.last_byte && (n1 != 2'd3);
    rec_o      = '{bytes: v, cnt: n1, last: in_i.last_byte};
    rec_push_o = accept && !hold;
    win_d      = win_q;
    cnt_d      = cnt_q;
    if (accept) begin
      if (hold) begin
        win_d = {v[1], v[0]};
        cnt_d = n1;
      end else if (in_i.last_byte) begin
        win_d = '0;
        cnt_d = '0;
      end else begin
        win_d = {v[2], v[1]};
        cnt_d = 2'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      cnt_q <= '0;
    end else begin
      win_q <= win_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- sv/rro_back.sv -----
// Back end: emits a snapshot's first byte, or all of them at a region end, a byte per cycle
// unless stalled; matches headers and adds the delta to offset bytes with carry. Depends on rro_pkg.
module rro_back import rro_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [31:0] cfg_data_i,
  input  rro_rec_t    rec_i,
  input  logic        rec_empty_i,
  output logic        rec_pop_o,
  output logic        out_push_o,
  output rro_out_t    out_o,
  input  logic        out_full_i
);

  logic [31:0] delta_q;
  logic [1:0]  idx_d, idx_q;
  logic [1:0]  hdr_d, hdr_q;
  logic [2:0]  off_d, off_q;
  logic        carry_d, carry_q;

  logic [1:0]  hdr_c;
  logic [2:0]  off_c;
  logic        carry_c;
  logic [7:0]  b, nx1, nx2, d;
  logic [1:0]  k, emit;
  logic [8:0]  sum;
  logic        go, done, avail2, avail3, patched;

  always_comb begin
    case (idx_q)
      2'd0: begin
        b = rec_i.bytes[0]; nx1 = rec_i.bytes[1]; nx2 = rec_i.bytes[2];
      end
      2'd1: begin
        b = rec_i.bytes[1]; nx1 = rec_i.bytes[2]; nx2 = 8'h00;
      end
      default: begin
        b = rec_i.bytes[2]; nx1 = 8'h00; nx2 = 8'h00;
      end
    endcase
    avail3 = (idx_q == 2'd0) && (rec_i.cnt == 2'd3);
    avail2 = ({1'b0, rec_i.cnt} > ({1'b0, idx_q} + 3'd1));
    k      = 2'(off_q - 3'd1);
    d      = delta_q[{k, 3'b000} +: 8];
    sum    = {1'b0, b} + {1'b0, d} + {8'h00, carry_q};

    hdr_c   = hdr_q;
    off_c   = off_q;
    carry_c = carry_q;
    patched = 1'b0;
    out_o.out_byte = b;
    if (hdr_q != 2'd0) begin
      hdr_c = hdr_q - 2'd1;
      if (hdr_q == 2'd1) begin
        off_c   = 3'd1;
        carry_c = 1'b0;
      end
    end else if (off_q != 3'd0) begin
      carry_c        = sum[8];
      off_c          = (off_q == 3'd4) ? 3'd0 : off_q + 3'd1;
      patched        = 1'b1;
      out_o.out_byte = sum[7:0];
    end else begin
      off_c = 3'd0;
      if (avail3 && long_header(b, nx1, nx2)) begin
        hdr_c = 2'd2;
      end else if (avail2 && b == OpGrp5 && (nx1 inside {ModrmCall, ModrmJmp})) begin
        hdr_c = 2'd1;
      end else if (b inside {OpCall, OpJmp}) begin
        off_c   = 3'd1;
        carry_c = 1'b0;
      end
    end

    emit = rec_i.last ? rec_i.cnt : 2'd1;
    done = (idx_q + 2'd1 == emit);
    go   = !rec_empty_i && !out_full_i;

    out_o.was_patched   = patched;
    out_o.end_of_region = rec_i.last && done;
    out_push_o          = go;
    rec_pop_o           = go && done;

    idx_d   = idx_q;
    hdr_d   = hdr_q;
    off_d   = off_q;
    carry_d = carry_q;
    if (go) begin
      if (done && rec_i.last) begin
        idx_d   = '0;
        hdr_d   = '0;
        off_d   = '0;
        carry_d = 1'b0;
      end else begin
        idx_d   = done ? 2'd0 : idx_q + 2'd1;
        hdr_d   = hdr_c;
        off_d   = off_c;
        carry_d = carry_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= '0;
      idx_q   <= '0;
      hdr_q   <= '0;
      off_q   <= '0;
      carry_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        delta_q <= cfg_data_i;
      end
      idx_q   <= idx_d;
      hdr_q   <= hdr_d;
      off_q   <= off_d;
      carry_q <= carry_d;
    end
  end

endmodule

// ----- verif/rip_relative_offset_relocator_unit_test.sv -----
// Testbench for rip_relative_offset_relocator_unit: directed and random x86-64 byte
// regions, checked byte for byte against a relocation predictor. Depends on rro_pkg.
`timescale 1ns / 100ps

module rip_relative_offset_relocator_unit_test;
  import rro_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned SettleCycles  = 8;

  class relocated_byte_board;
    logic [31:0] delta;
    logic [7:0]  win [2];
    logic [7:0]  view [3];
    int          win_cnt;
    int          hdr_left;
    int          off_idx;
    bit          carry;
    rro_out_t    relocated_q [$];
    int unsigned bytes_in;
    int unsigned regions;
    int unsigned checked;
    int unsigned patched_seen;

    function new();
      delta        = '0;
      bytes_in     = 0;
      regions      = 0;
      checked      = 0;
      patched_seen = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      win[0]   = '0;
      win[1]   = '0;
      win_cnt  = 0;
      hdr_left = 0;
      off_idx  = 0;
      carry    = 1'b0;
    endfunction

    function bit rip_header(logic [7:0] p, logic [7:0] op, logic [7:0] m);
      logic [7:0] regs;
      if (m[7:6] != 2'b00 || m[2:0] != 3'b101) return 1'b0;
      case ({p, op})
        {RexW, OpLea}:                                 regs = 8'b0000_0110;
        {RexW, OpCmp}:                                 regs = 8'b0000_1110;
        {RexW, OpMov}, {RexWR, OpMov}, {RexWR, OpCmp}: regs = 8'hFF;
        default:                                       regs = 8'h00;
      endcase
      return regs[m[5:3]];
    endfunction

    function logic [7:0] classify(int i, int n, output bit patched);
      logic [7:0] b;
      logic [8:0] sum;
      b       = view[i];
      patched = 1'b0;
      if (hdr_left > 0) begin
        hdr_left--;
        if (hdr_left == 0) begin
          off_idx = 1;
          carry   = 1'b0;
        end
        return b;
      end
      if (off_idx >= 1 && off_idx <= 4) begin
        sum     = {1'b0, b} + {1'b0, delta[8*(off_idx-1) +: 8]} + {8'd0, carry};
        carry   = sum[8];
        off_idx = (off_idx == 4) ? 0 : off_idx + 1;
        patched = 1'b1;
        return sum[7:0];
      end
      off_idx = 0;
      if (n - i >= 3 && rip_header(b, view[i+1], view[i+2])) begin
        hdr_left = 2;
      end else if (n - i >= 2 && b == OpGrp5 &&
                   (view[i+1] == ModrmCall || view[i+1] == ModrmJmp)) begin
        hdr_left = 1;
      end else if (b == OpCall || b == OpJmp) begin
        off_idx = 1;
        carry   = 1'b0;
      end
      return b;
    endfunction

    function void note_code_byte(rro_in_t item);
      int       n;
      int       emit;
      bit       p;
      rro_out_t r;
      bytes_in++;
      n       = win_cnt;
      view[0] = win[0];
      view[1] = win[1];
      view[2] = '0;
      view[n] = item.code_byte;
      n++;
      if (!item.last_byte && n < 3) begin
        win[0]  = view[0];
        win[1]  = view[1];
        win_cnt = n;
        return;
      end
      emit = item.last_byte ? n : 1;
      for (int i = 0; i < emit; i++) begin
        r.out_byte      = classify(i, n, p);
        r.was_patched   = p;
        r.end_of_region = item.last_byte && (i == emit - 1);
        relocated_q.push_back(r);
      end
      if (item.last_byte) begin
        regions++;
        clear_stream();
      end else begin
        win[0]  = view[1];
        win[1]  = view[2];
        win_cnt = 2;
      end
    endfunction

    function bit check_out_byte(rro_out_t got, output string why);
      rro_out_t want;
      why = "";
      if (relocated_q.size() == 0) begin
        why = $sformatf("unexpected result byte=%02h patched=%0b end=%0b",
                        got.out_byte, got.was_patched, got.end_of_region);
        return 1'b0;
      end
      want = relocated_q.pop_front();
      checked++;
      if (want.was_patched) patched_seen++;
      if (got.out_byte !== want.out_byte)
        why = {why, $sformatf(" out_byte %02h exp %02h", got.out_byte, want.out_byte)};
      if (got.was_patched !== want.was_patched)
        why = {why, $sformatf(" was_patched %0b exp %0b", got.was_patched, want.was_patched)};
      if (got.end_of_region !== want.end_of_region)
        why = {why, $sformatf(" end_of_region %0b exp %0b",
                              got.end_of_region, want.end_of_region)};
      if (why != "") why = $sformatf("result %0d:%s", checked, why);
      return why == "";
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  rro_in_t     in_i        = '0;
  logic        empty;
  logic        pop         = 1'b0;
  rro_out_t    out_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i  = '0;

  relocated_byte_board board = new();

  int unsigned error_count    = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned delta_writes   = 0;
  logic [7:0]  region_q [$];

  rip_relative_offset_relocator_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    string why;
    if (rst_ni) begin
      if (push && !full) board.note_code_byte(in_i);
      if (pop && !empty) begin
        if (!board.check_out_byte(out_o, why)) report_mismatch(why);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("Watchdog: no transaction for %0d cycles", WatchdogLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random stalls plus long hold-offs on request.
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    rro_in_t item;
    item.code_byte = b;
    item.last_byte = last;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= item;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic send_region();
    foreach (region_q[k]) send_byte(region_q[k], k == region_q.size() - 1);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk_i);
    while (board.relocated_q.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_delta(logic [31:0] value);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    board.delta = value;
    delta_writes++;
  endtask

  function automatic void add_offset();
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(7))
        0:       region_q.push_back(8'hFF);
        1:       region_q.push_back(8'h00);
        default: region_q.push_back(8'($urandom()));
      endcase
    end
  endfunction

  function automatic void add_instruction();
    int unsigned sel;
    logic [2:0]  rg;
    sel = $urandom_range(99);
    rg  = 3'($urandom_range(7));
    if (sel < 30) begin
      case ($urandom_range(4))
        0: begin
          region_q.push_back(RexW);
          region_q.push_back(OpLea);
          rg = $urandom_range(1) ? 3'd1 : 3'd2;
        end
        1: begin
          region_q.push_back(RexW);
          region_q.push_back(OpMov);
        end
        2: begin
          region_q.push_back(RexW);
          region_q.push_back(OpCmp);
          rg = 3'($urandom_range(1, 3));
        end
        3: begin
          region_q.push_back(RexWR);
          region_q.push_back(OpMov);
        end
        default: begin
          region_q.push_back(RexWR);
          region_q.push_back(OpCmp);
        end
      endcase
      region_q.push_back({2'b00, rg, 3'b101});
      add_offset();
    end else if (sel < 45) begin
      region_q.push_back(OpGrp5);
      region_q.push_back($urandom_range(1) ? ModrmCall : ModrmJmp);
      add_offset();
    end else if (sel < 65) begin
      region_q.push_back($urandom_range(1) ? OpCall : OpJmp);
      add_offset();
    end else if (sel < 80) begin
      // near misses: right prefix or opcode, register or addressing form random (may still match)
      region_q.push_back($urandom_range(3) == 0 ? OpGrp5 :
                         ($urandom_range(1) ? RexW : RexWR));
      case ($urandom_range(3))
        0:       region_q.push_back(OpLea);
        1:       region_q.push_back(OpCmp);
        2:       region_q.push_back(OpMov);
        default: region_q.push_back(8'($urandom()));
      endcase
      region_q.push_back($urandom_range(1) ? {2'b00, rg, 3'b101} : 8'($urandom()));
      if ($urandom_range(1)) add_offset();
    end else begin
      repeat ($urandom_range(1, 3)) region_q.push_back(8'($urandom()));
    end
  endfunction

  task automatic run_phase(int unsigned n_items, int unsigned idle_pct,
                           int unsigned stall_pct, bit hold_mid, bit pause_mid);
    int unsigned sent;
    int unsigned len;
    bit          held;
    bit          paused;
    sent           = 0;
    held           = 1'b0;
    paused         = 1'b0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < n_items) begin
      region_q.delete();
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
      while (region_q.size() < len) add_instruction();
      while (region_q.size() > len) void'(region_q.pop_back());
      foreach (region_q[k]) begin
        send_byte(region_q[k], k == region_q.size() - 1);
        sent++;
        if (hold_mid && !held && sent >= n_items / 4) begin
          held = 1'b1;
          hold_requests++;
        end
        if (pause_mid && !paused && sent >= n_items / 2) begin
          paused = 1'b1;
          wait_drained();
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // carry chains, offset and header cut off by the region end, one-byte region
    write_delta(32'h0000_0001);
    region_q = '{OpCall, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_region();
    region_q = '{OpGrp5, ModrmJmp, 8'h12, 8'h34, 8'h56};
    send_region();
    region_q = '{RexW, OpMov};
    send_region();
    region_q = '{OpJmp};
    send_region();
    wait_drained();

    write_delta(32'hFFFF_FFFF);
    region_q = '{RexW, OpLea, 8'h15, 8'h00, 8'h00, 8'h00, 8'h80};
    send_region();
    region_q = '{RexWR, OpCmp, 8'h3D, 8'hFF, 8'hFF};
    send_region();
    wait_drained();

    write_delta(32'h7FFF_FFFF);
    run_phase(100, 0, 0, 1'b1, 1'b0);
    write_delta(32'h8000_0000);
    run_phase(100, 58, 0, 1'b0, 1'b1);
    write_delta($urandom());
    run_phase(100, 0, 58, 1'b0, 1'b0);
    write_delta(32'h0000_0000);
    run_phase(100, 19, 19, 1'b0, 1'b0);

    repeat (SettleCycles) @(posedge clk_i);
    if (board.relocated_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                board.relocated_q.size()));
    $display("Run covered %0d code bytes in %0d regions under %0d delta settings",
             board.bytes_in, board.regions, delta_writes);
    $display("Checked %0d output bytes, %0d of them relocated offset bytes",
             board.checked, board.patched_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
